// ===== hdl/dsc_pkg.sv =====
`timescale 1ns / 1ps

package dsc_pkg;

    // Input kinds (s_axis_tuser)
    localparam logic [1:0] KIND_LOAD_PROC  = 2'd0;
    localparam logic [1:0] KIND_LOAD_AVAIL = 2'd1;
    localparam logic [1:0] KIND_CHECK      = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_PROCS = 1'b0;
    localparam logic REG_RES   = 1'b1;

    // Register reset values
    localparam logic [3:0] PROCS_RST = 4'd8;
    localparam logic [2:0] RES_RST   = 3'd4;

    // Field widths fixed by the stream format
    localparam int KIND_W  = 2;
    localparam int PIDX_W  = 3;
    localparam int RIDX_W  = 2;
    localparam int UNITS_W = 16;
    localparam int PNUM_W  = 3;
    localparam int PROCS_W = 4;
    localparam int RES_W   = 3;

    // Input tdata layout, lowest field first
    localparam int PIDX_LSB  = 0;
    localparam int RIDX_LSB  = PIDX_LSB + PIDX_W;
    localparam int ALLOC_LSB = RIDX_LSB + RIDX_W;
    localparam int MAX_LSB   = ALLOC_LSB + UNITS_W;
    localparam int AVAIL_LSB = MAX_LSB + UNITS_W;
    localparam int S_TDATA_W = ((AVAIL_LSB + UNITS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    // APB
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Check request from the front end to the engine
    typedef struct packed {
        logic               start;
        logic [PROCS_W-1:0] procs;
        logic [RES_W-1:0]   res;
    } t_chk_cmd;

    // One result item
    typedef struct packed {
        logic              is_safe;
        logic [PNUM_W-1:0] process_number;
        logic              last;
    } t_result;

endpackage

// ===== hdl/dsc_ram.sv =====
`timescale 1ns / 1ps

module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // one write port, one registered read port; read data holds without i_re
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== hdl/dsc_engine.sv =====
`timescale 1ns / 1ps

module dsc_engine #(
    parameter int PROCESSES  = 8,
    parameter int RESOURCES  = 4,
    parameter int VALUE_BITS = 16,
    localparam int TAW = (PROCESSES * RESOURCES > 1) ? $clog2(PROCESSES * RESOURCES) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dsc_pkg::t_chk_cmd         i_cmd,
    input  logic [VALUE_BITS-1:0]     i_avail [RESOURCES],
    output logic                      o_tbl_re,
    output logic [TAW-1:0]            o_tbl_raddr,
    input  logic [2*VALUE_BITS-1:0]   i_tbl_rdata,
    output logic                      o_busy,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output dsc_pkg::t_result          o_res
);

    localparam int PIW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int RIW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int CW  = $clog2(PROCESSES + 1);
    localparam int RCW = $clog2(RESOURCES + 1);
    localparam int WW  = VALUE_BITS + $clog2(PROCESSES + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EV   = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_ERD  = 3'd5;
    localparam logic [2:0] ST_EWR  = 3'd6;
    localparam logic [2:0] ST_UNS  = 3'd7;

    logic [2:0]              r_st, n_st;
    logic [CW-1:0]           r_np, n_np;
    logic [RCW-1:0]          r_nr, n_nr;
    logic [PIW-1:0]          r_p, n_p;
    logic [PIW-1:0]          r_pass, n_pass;
    logic [RIW-1:0]          r_res, n_res;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [PIW-1:0]          r_e, n_e;
    logic                    r_ovld, n_ovld;
    dsc_pkg::t_result        r_out, n_out;
    logic [PROCESSES-1:0]    r_fin;
    logic [WW-1:0]           r_work [RESOURCES];
    logic [VALUE_BITS-1:0]   r_abuf [RESOURCES];

    logic [VALUE_BITS-1:0]   v_alloc, v_max, v_need;
    logic                    fit, last_p, last_pass, last_r, last_e, slot_free;
    logic                    adv, do_init, do_add, fin_set, abuf_we, ord_we, ord_re;
    logic [dsc_pkg::PNUM_W-1:0] ord_q;

    // need = maximum - allocated; a negative need always fits
    assign v_alloc   = i_tbl_rdata[VALUE_BITS-1:0];
    assign v_max     = i_tbl_rdata[2*VALUE_BITS-1:VALUE_BITS];
    assign v_need    = v_max - v_alloc;
    assign fit       = !((v_max > v_alloc) && (WW'(v_need) > r_work[r_res]));

    assign last_p    = (CW'(r_p) + CW'(1)) == r_np;
    assign last_pass = (CW'(r_pass) + CW'(1)) == r_np;
    assign last_e    = (CW'(r_e) + CW'(1)) == r_np;
    assign last_r    = (RCW'(r_res) + RCW'(1)) == r_nr;
    assign slot_free = !r_ovld || i_res_ready;

    // row element address: first resource on RD, the following one in EV
    assign o_tbl_raddr = TAW'(int'(r_p) * RESOURCES +
                              ((r_st == ST_EV) ? int'(r_res) + 1 : 0));

    // sequencer
    always_comb begin
        n_st     = r_st;
        n_np     = r_np;
        n_nr     = r_nr;
        n_p      = r_p;
        n_pass   = r_pass;
        n_res    = r_res;
        n_cnt    = r_cnt;
        n_e      = r_e;
        n_out    = r_out;
        n_ovld   = r_ovld && !i_res_ready;
        o_tbl_re = 1'b0;
        adv      = 1'b0;
        do_init  = 1'b0;
        do_add   = 1'b0;
        fin_set  = 1'b0;
        abuf_we  = 1'b0;
        ord_we   = 1'b0;
        ord_re   = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_cmd.start) begin
                    do_init = 1'b1;
                    n_np    = CW'(i_cmd.procs);
                    n_nr    = RCW'(i_cmd.res);
                    n_p     = '0;
                    n_pass  = '0;
                    n_cnt   = '0;
                    n_st    = ST_RD;
                end
            end
            ST_RD: begin
                if (r_fin[r_p]) begin
                    adv = 1'b1;
                end else begin
                    o_tbl_re = 1'b1;
                    n_res    = '0;
                    n_st     = ST_EV;
                end
            end
            ST_EV: begin
                abuf_we = 1'b1;
                if (!fit) begin
                    adv = 1'b1;
                end else if (last_r) begin
                    n_st = ST_ADD;
                end else begin
                    o_tbl_re = 1'b1;
                    n_res    = r_res + RIW'(1);
                end
            end
            ST_ADD: begin
                do_add  = 1'b1;
                fin_set = 1'b1;
                ord_we  = 1'b1;
                n_cnt   = r_cnt + CW'(1);
                adv     = 1'b1;
            end
            ST_DONE: begin
                n_e  = '0;
                n_st = (r_cnt == r_np) ? ST_ERD : ST_UNS;
            end
            ST_ERD: begin
                ord_re = 1'b1;
                n_st   = ST_EWR;
            end
            ST_EWR: begin
                if (slot_free) begin
                    n_ovld               = 1'b1;
                    n_out.is_safe        = 1'b1;
                    n_out.process_number = ord_q;
                    n_out.last           = last_e;
                    n_e                  = r_e + PIW'(1);
                    n_st                 = last_e ? ST_IDLE : ST_ERD;
                end
            end
            ST_UNS: begin
                if (slot_free) begin
                    n_ovld               = 1'b1;
                    n_out.is_safe        = 1'b0;
                    n_out.process_number = '0;
                    n_out.last           = 1'b1;
                    n_st                 = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase

        // step to the next process, wrapping into the next pass
        if (adv) begin
            if (last_p) begin
                n_p = '0;
                if (last_pass) begin
                    n_st = ST_DONE;
                end else begin
                    n_pass = r_pass + PIW'(1);
                    n_st   = ST_RD;
                end
            end else begin
                n_p  = r_p + PIW'(1);
                n_st = ST_RD;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_np   <= '0;
            r_nr   <= '0;
            r_p    <= '0;
            r_pass <= '0;
            r_res  <= '0;
            r_cnt  <= '0;
            r_e    <= '0;
            r_ovld <= 1'b0;
            r_fin  <= '0;
        end else begin
            r_st   <= n_st;
            r_np   <= n_np;
            r_nr   <= n_nr;
            r_p    <= n_p;
            r_pass <= n_pass;
            r_res  <= n_res;
            r_cnt  <= n_cnt;
            r_e    <= n_e;
            r_ovld <= n_ovld;
            if (do_init) begin
                r_fin <= '0;
            end else if (fin_set) begin
                r_fin[r_p] <= 1'b1;
            end
        end
    end

    // work vector: loaded from available, grows by each finished allocation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RESOURCES; i++) begin
                r_work[i] <= '0;
            end
        end else begin
            for (int i = 0; i < RESOURCES; i++) begin
                if (do_init) begin
                    r_work[i] <= WW'(i_avail[i]);
                end else if (do_add && (i < int'(r_nr))) begin
                    r_work[i] <= r_work[i] + WW'(r_abuf[i]);
                end
            end
        end
    end

    // payload: allocation row buffer and output register
    always_ff @(posedge i_clk) begin
        if (abuf_we) begin
            r_abuf[r_res] <= v_alloc;
        end
        r_out <= n_out;
    end

    // safe order store
    dsc_ram #(
        .WIDTH (dsc_pkg::PNUM_W),
        .DEPTH (PROCESSES)
    ) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (r_cnt[PIW-1:0]),
        .i_wdata (dsc_pkg::PNUM_W'(r_p)),
        .i_re    (ord_re),
        .i_raddr (r_e),
        .o_rdata (ord_q)
    );

    assign o_busy      = r_st != ST_IDLE;
    assign o_res_valid = r_ovld;
    assign o_res       = r_out;

endmodule

// ===== hdl/deadlock_safety_checker.sv =====
`timescale 1ns / 1ps
// Load requests: one per cycle while no check is in progress, no result.
// Check request: up to np passes of table walk over the unfinished processes (one table
// RAM read per resource element, one step per process visit, one to add), then each
// result is read from the order RAM and written out; np, nr are the clamped registers.
// Reset (synchronous, active low) clears control, the work vector and the registers
// to 8 and 4; the tables hold nothing defined until loaded, there is no clearing pass.
module deadlock_safety_checker #(
    parameter int PROCESSES  = 8,
    parameter int RESOURCES  = 4,
    parameter int VALUE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // process_index, resource_index, allocated_units, maximum_units, available_units
    input  logic [dsc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [dsc_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // process_number
    output logic [dsc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // is_safe
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dsc_pkg::APB_AW-1:0]     paddr,
    input  logic [dsc_pkg::APB_DW-1:0]     pwdata,
    output logic [dsc_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int TAW = (PROCESSES * RESOURCES > 1) ? $clog2(PROCESSES * RESOURCES) : 1;
    localparam int RIW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

    logic [dsc_pkg::PROCS_W-1:0] r_procs_in_use;
    logic [dsc_pkg::RES_W-1:0]   r_res_in_use;
    logic [VALUE_BITS-1:0]       r_avail [RESOURCES];

    logic                        s_acc, cfg_we, eng_busy;
    logic [dsc_pkg::KIND_W-1:0]  in_kind;
    logic [dsc_pkg::PIDX_W-1:0]  in_pidx;
    logic [dsc_pkg::RIDX_W-1:0]  in_ridx;
    logic [dsc_pkg::UNITS_W-1:0] in_alloc, in_max, in_avail;
    logic                        tbl_we, avail_we, tbl_re;
    logic [TAW-1:0]              tbl_waddr, tbl_raddr;
    logic [2*VALUE_BITS-1:0]     tbl_wdata, tbl_rdata;
    dsc_pkg::t_chk_cmd           cmd;
    dsc_pkg::t_result            res;

    // input field decode
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign in_kind  = s_axis_tuser;
    assign in_pidx  = s_axis_tdata[dsc_pkg::PIDX_LSB +: dsc_pkg::PIDX_W];
    assign in_ridx  = s_axis_tdata[dsc_pkg::RIDX_LSB +: dsc_pkg::RIDX_W];
    assign in_alloc = s_axis_tdata[dsc_pkg::ALLOC_LSB +: dsc_pkg::UNITS_W];
    assign in_max   = s_axis_tdata[dsc_pkg::MAX_LSB +: dsc_pkg::UNITS_W];
    assign in_avail = s_axis_tdata[dsc_pkg::AVAIL_LSB +: dsc_pkg::UNITS_W];

    // loads with an index out of range are dropped
    assign tbl_we    = s_acc && (in_kind == dsc_pkg::KIND_LOAD_PROC) &&
                       (int'(in_pidx) < PROCESSES) && (int'(in_ridx) < RESOURCES);
    assign avail_we  = s_acc && (in_kind == dsc_pkg::KIND_LOAD_AVAIL) &&
                       (int'(in_ridx) < RESOURCES);
    assign tbl_waddr = TAW'(int'(in_pidx) * RESOURCES + int'(in_ridx));
    assign tbl_wdata = {VALUE_BITS'(in_max), VALUE_BITS'(in_alloc)};

    // available vector
    always_ff @(posedge i_clk) begin
        if (avail_we) begin
            r_avail[RIW'(in_ridx)] <= VALUE_BITS'(in_avail);
        end
    end

    // configuration registers
    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_procs_in_use <= dsc_pkg::PROCS_RST;
            r_res_in_use   <= dsc_pkg::RES_RST;
        end else if (cfg_we) begin
            case (paddr[2])
                dsc_pkg::REG_PROCS: r_procs_in_use <= pwdata[dsc_pkg::PROCS_W-1:0];
                dsc_pkg::REG_RES:   r_res_in_use   <= pwdata[dsc_pkg::RES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dsc_pkg::REG_PROCS: prdata = dsc_pkg::APB_DW'(r_procs_in_use);
            dsc_pkg::REG_RES:   prdata = dsc_pkg::APB_DW'(r_res_in_use);
            default:            prdata = '0;
        endcase
    end

    // check request with counts clamped to 1..max
    always_comb begin
        cmd.start = s_acc && (in_kind == dsc_pkg::KIND_CHECK);
        if (r_procs_in_use == '0) begin
            cmd.procs = dsc_pkg::PROCS_W'(1);
        end else if (int'(r_procs_in_use) > PROCESSES) begin
            cmd.procs = dsc_pkg::PROCS_W'(PROCESSES);
        end else begin
            cmd.procs = r_procs_in_use;
        end
        if (r_res_in_use == '0) begin
            cmd.res = dsc_pkg::RES_W'(1);
        end else if (int'(r_res_in_use) > RESOURCES) begin
            cmd.res = dsc_pkg::RES_W'(RESOURCES);
        end else begin
            cmd.res = r_res_in_use;
        end
    end

    // allocated / maximum table, one row element per entry
    dsc_ram #(
        .WIDTH (2 * VALUE_BITS),
        .DEPTH (PROCESSES * RESOURCES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    dsc_engine #(
        .PROCESSES  (PROCESSES),
        .RESOURCES  (RESOURCES),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_avail     (r_avail),
        .o_tbl_re    (tbl_re),
        .o_tbl_raddr (tbl_raddr),
        .i_tbl_rdata (tbl_rdata),
        .o_busy      (eng_busy),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign s_axis_tready = !eng_busy;
    assign m_axis_tdata  = dsc_pkg::M_TDATA_W'(res.process_number);
    assign m_axis_tuser  = res.is_safe;
    assign m_axis_tlast  = res.last;

    // a check request takes the engine off the input side at once
    a_check_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (in_kind == dsc_pkg::KIND_CHECK)) |=> !s_axis_tready)
        else $error("input still ready after check request");

    // table is never written while the engine walks it
    a_no_load_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |-> !eng_busy)
        else $error("table write during check");

    // an unsafe result is a single final item naming process zero
    a_unsafe_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("malformed unsafe result");

endmodule

// ===== test/tb_deadlock_safety_checker.sv =====
`timescale 1ns / 1ps

module tb_deadlock_safety_checker;

    localparam int          NPROC       = 8;
    localparam int          NRES        = 4;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    // Holds the loaded tables and registers, predicts the safe order of each check
    class safe_order_board;
        logic [dsc_pkg::UNITS_W-1:0] held [NPROC][NRES];
        logic [dsc_pkg::UNITS_W-1:0] claim [NPROC][NRES];
        logic [dsc_pkg::UNITS_W-1:0] free_units [NRES];
        logic [dsc_pkg::PROCS_W-1:0] procs_reg;
        logic [dsc_pkg::RES_W-1:0]   res_reg;
        dsc_pkg::t_result            expected_order [$];
        int                          mismatches;

        function new();
            procs_reg  = dsc_pkg::PROCS_RST;
            res_reg    = dsc_pkg::RES_RST;
            mismatches = 0;
        endfunction

        function void set_register(logic reg_sel, logic [dsc_pkg::APB_DW-1:0] value);
            if (reg_sel == dsc_pkg::REG_PROCS) begin
                procs_reg = value[dsc_pkg::PROCS_W-1:0];
            end else begin
                res_reg = value[dsc_pkg::RES_W-1:0];
            end
        endfunction

        // Replays the walk: passes over unfinished processes, admit when need fits
        function void predict_safe_order();
            int                         np;
            int                         nr;
            int                         count;
            logic [19:0]                work [NRES];
            bit                         done [NPROC];
            logic [dsc_pkg::PNUM_W-1:0] order [NPROC];
            bit                         fits;
            dsc_pkg::t_result           item;
            np = (procs_reg == 0) ? 1 : (procs_reg > NPROC) ? NPROC : int'(procs_reg);
            nr = (res_reg == 0) ? 1 : (res_reg > NRES) ? NRES : int'(res_reg);
            count = 0;
            for (int r = 0; r < NRES; r++) work[r] = {4'd0, free_units[r]};
            for (int p = 0; p < NPROC; p++) done[p] = 1'b0;
            for (int round = 0; round < np; round++) begin
                for (int p = 0; p < np; p++) begin
                    if (!done[p]) begin
                        fits = 1'b1;
                        // negative need always fits
                        for (int r = 0; r < nr; r++)
                            if (claim[p][r] > held[p][r] &&
                                {4'd0, claim[p][r] - held[p][r]} > work[r])
                                fits = 1'b0;
                        if (fits) begin
                            order[count] = p[dsc_pkg::PNUM_W-1:0];
                            count++;
                            for (int r = 0; r < nr; r++) work[r] += {4'd0, held[p][r]};
                            done[p] = 1'b1;
                        end
                    end
                end
            end
            if (count < np) begin
                item.is_safe        = 1'b0;
                item.process_number = '0;
                item.last           = 1'b1;
                expected_order.push_back(item);
            end else begin
                for (int i = 0; i < np; i++) begin
                    item.is_safe        = 1'b1;
                    item.process_number = order[i];
                    item.last           = (i == np - 1);
                    expected_order.push_back(item);
                end
            end
        endfunction

        function void note_request(logic [dsc_pkg::KIND_W-1:0] kind,
                                   logic [dsc_pkg::PIDX_W-1:0] pidx,
                                   logic [dsc_pkg::RIDX_W-1:0] ridx,
                                   logic [dsc_pkg::UNITS_W-1:0] alloc,
                                   logic [dsc_pkg::UNITS_W-1:0] maxu,
                                   logic [dsc_pkg::UNITS_W-1:0] avail);
            case (kind)
                dsc_pkg::KIND_LOAD_PROC: begin
                    held[pidx][ridx]  = alloc;
                    claim[pidx][ridx] = maxu;
                end
                dsc_pkg::KIND_LOAD_AVAIL: begin
                    free_units[ridx] = avail;
                end
                dsc_pkg::KIND_CHECK: begin
                    predict_safe_order();
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic is_safe, logic [dsc_pkg::M_TDATA_W-1:0] tdata,
                                   logic last);
            dsc_pkg::t_result want;
            if (expected_order.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result safe=%b proc=%0d last=%b",
                             $realtime, is_safe, tdata, last);
                return;
            end
            want = expected_order.pop_front();
            if (is_safe !== want.is_safe || last !== want.last ||
                tdata !== dsc_pkg::M_TDATA_W'(want.process_number)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch exp safe=%b proc=%0d last=%b",
                              " got safe=%b proc=%0d last=%b"},
                             $realtime, want.is_safe, want.process_number, want.last,
                             is_safe, tdata, last);
            end
        endfunction
    endclass

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [dsc_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [dsc_pkg::KIND_W-1:0]      s_axis_tuser  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [dsc_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic [0:0]                      m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [dsc_pkg::APB_AW-1:0]      paddr         = '0;
    logic [dsc_pkg::APB_DW-1:0]      pwdata        = '0;
    logic [dsc_pkg::APB_DW-1:0]      prdata;
    logic                            pready;

    safe_order_board        board = new();
    int                     idle_pct  = 0;
    int                     stall_pct = 0;
    bit                     hold_off  = 1'b0;
    int                     cycle_count = 0;

    deadlock_safety_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser[0], m_axis_tdata, m_axis_tlast);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One request on the input stream; returns at the falling edge after acceptance
    task automatic send_request(input logic [dsc_pkg::KIND_W-1:0] kind,
                                input logic [dsc_pkg::PIDX_W-1:0] pidx,
                                input logic [dsc_pkg::RIDX_W-1:0] ridx,
                                input logic [dsc_pkg::UNITS_W-1:0] alloc,
                                input logic [dsc_pkg::UNITS_W-1:0] maxu,
                                input logic [dsc_pkg::UNITS_W-1:0] avail);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        // pidx lowest, then ridx, alloc, max, avail
        s_axis_tdata  = dsc_pkg::S_TDATA_W'({avail, maxu, alloc, ridx, pidx});
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(kind, pidx, ridx, alloc, maxu, avail);
        @(negedge i_clk);
    endtask

    task automatic check_now;
        send_request(dsc_pkg::KIND_CHECK, dsc_pkg::PIDX_W'($urandom),
                     dsc_pkg::RIDX_W'($urandom), dsc_pkg::UNITS_W'($urandom),
                     dsc_pkg::UNITS_W'($urandom), dsc_pkg::UNITS_W'($urandom));
    endtask

    // Stop sending, wait for every expected result, then let trailing loads settle
    task automatic drain_results(input int settle);
        s_axis_tvalid = 1'b0;
        while (board.expected_order.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic reg_sel,
                                  input logic [dsc_pkg::APB_DW-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_register(reg_sel, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Mostly small unit counts so checks often succeed, now and then full range
    function automatic logic [dsc_pkg::UNITS_W-1:0] random_units(input int span);
        if ($urandom_range(9) == 0) return dsc_pkg::UNITS_W'($urandom_range(65535));
        return dsc_pkg::UNITS_W'($urandom_range(span));
    endfunction

    task automatic send_random_request;
        int                          pick;
        logic [dsc_pkg::UNITS_W-1:0] alloc;
        logic [dsc_pkg::UNITS_W-1:0] maxu;
        pick  = $urandom_range(99);
        alloc = random_units(12);
        maxu  = ($urandom_range(3) == 0) ? random_units(12) :
                dsc_pkg::UNITS_W'(alloc + $urandom_range(6));
        if (pick < 55) begin
            send_request(dsc_pkg::KIND_LOAD_PROC, dsc_pkg::PIDX_W'($urandom),
                         dsc_pkg::RIDX_W'($urandom), alloc, maxu,
                         dsc_pkg::UNITS_W'($urandom));
        end else if (pick < 70) begin
            send_request(dsc_pkg::KIND_LOAD_AVAIL, dsc_pkg::PIDX_W'($urandom),
                         dsc_pkg::RIDX_W'($urandom), dsc_pkg::UNITS_W'($urandom),
                         dsc_pkg::UNITS_W'($urandom), random_units(20));
        end else if (pick < 95) begin
            check_now();
        end else begin
            send_request(KIND_UNUSED, dsc_pkg::PIDX_W'($urandom),
                         dsc_pkg::RIDX_W'($urandom), dsc_pkg::UNITS_W'($urandom),
                         dsc_pkg::UNITS_W'($urandom), dsc_pkg::UNITS_W'($urandom));
        end
    endtask

    int phase_idle  [6] = '{0, 69, 0, 36, 0, 36};
    int phase_stall [6] = '{0, 0, 69, 36, 0, 36};
    int phase_procs [6] = '{8, 3, 1, 8, 6, 15};
    int phase_res   [6] = '{4, 2, 4, 1, 3, 0};

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Fill every table entry before the first check
        for (int p = 0; p < NPROC; p++)
            for (int r = 0; r < NRES; r++)
                send_request(dsc_pkg::KIND_LOAD_PROC, dsc_pkg::PIDX_W'(p),
                             dsc_pkg::RIDX_W'(r), random_units(8), random_units(10),
                             dsc_pkg::UNITS_W'($urandom));
        for (int r = 0; r < NRES; r++)
            send_request(dsc_pkg::KIND_LOAD_AVAIL, dsc_pkg::PIDX_W'($urandom),
                         dsc_pkg::RIDX_W'(r), dsc_pkg::UNITS_W'($urandom),
                         dsc_pkg::UNITS_W'($urandom), random_units(16));

        // Directed: reset register values, full availability, extreme elements
        check_now();
        for (int r = 0; r < NRES; r++)
            send_request(dsc_pkg::KIND_LOAD_AVAIL, 3'd0, dsc_pkg::RIDX_W'(r), '0, '0,
                         16'hFFFF);
        check_now();
        // held above its maximum (negative need) and a full-range claim with none free
        send_request(dsc_pkg::KIND_LOAD_PROC, 3'd0, 2'd0, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(dsc_pkg::KIND_LOAD_PROC, 3'd7, 2'd3, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_request(dsc_pkg::KIND_LOAD_AVAIL, 3'd7, 2'd3, 16'hFFFF, 16'hFFFF, 16'h0000);
        // unused kind with every data bit set is ignored
        send_request(KIND_UNUSED, 3'd7, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        check_now();
        send_request(dsc_pkg::KIND_LOAD_PROC, 3'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000);
        send_request(dsc_pkg::KIND_LOAD_PROC, 3'd7, 2'd3, 16'h0001, 16'h0002, 16'h0000);
        // zero registers act as one
        drain_results(50);
        write_register(dsc_pkg::REG_PROCS, 32'd0);
        write_register(dsc_pkg::REG_RES, 32'd0);
        check_now();
        // too-large registers act as the maximum
        drain_results(50);
        write_register(dsc_pkg::REG_PROCS, 32'hFFFF_FFFF);
        write_register(dsc_pkg::REG_RES, 32'hFFFF_FFFF);
        check_now();
        drain_results(50);
        write_register(dsc_pkg::REG_PROCS, 32'd1);
        write_register(dsc_pkg::REG_RES, 32'd1);
        check_now();
        drain_results(50);

        // Random phases with different idling, backpressure and register settings
        for (int ph = 0; ph < 6; ph++) begin
            write_register(dsc_pkg::REG_PROCS, dsc_pkg::APB_DW'(phase_procs[ph]));
            write_register(dsc_pkg::REG_RES, dsc_pkg::APB_DW'(phase_res[ph]));
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            // long receiver hold so the block fills and stalls its input
            if (ph == 4) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (1500) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            repeat (30) send_random_request();
            drain_results(50);
        end

        if (board.mismatches == 0 && board.expected_order.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
